// File: rtl/core/quoted_word_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Quoted word tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef QUOTED_WORD_TOKENIZER_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QWT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QWT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/qwt_pkg.sv
// ----------------------------------------------------------------------------
// Quoted word tokenizer package
// Result kinds, command entry types and queue sizing.
// ----------------------------------------------------------------------------
package qwt_pkg;

    localparam int QWT_QAW    = 2;
    localparam int QWT_QDEPTH = 1 << QWT_QAW;

    localparam logic [7:0] QWT_SQUOTE  = 8'h27;
    localparam logic [7:0] QWT_DQUOTE  = 8'h22;
    localparam logic [7:0] QWT_ESC_RST = 8'h5C;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOW  = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_res;

    // One queue entry: one or two results of a single input item.
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// File: rtl/core/quoted_word_tokenizer.sv
// ----------------------------------------------------------------------------
// Quoted word tokenizer
// Splits a byte stream into shell-style words with quotes and an escape byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one byte per transfer in i_char_in, or
//   an end-of-line item with i_line_end high. One item is taken per cycle
//   while the command queue has room.
//   Output channel (o_valid / i_ready): one result per transfer; o_kind is a
//   word byte, an end of word or an end of line, o_char_out the byte or zero.
//   An item yields zero, one or two results; a held escape byte comes out
//   together with the byte after it.
//   An accepted item goes into the queue, then into the output register
//   behind o_valid. Throughput: one item per cycle while the queue has room;
//   the output side moves one result per cycle while i_ready is high.
//   The four-entry queue lets input continue while the receiver stalls;
//   o_ready drops only when it is full.
//   i_cfg_we writes the escape byte from i_cfg_wdata; write only while idle.
//   Reset (synchronous, active low) empties the queue, clears line state and
//   restores backslash as the escape byte.
// ----------------------------------------------------------------------------
module quoted_word_tokenizer
    import qwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_char_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_qstat stat;
    t_cmd   push_cmd;
    t_cmd   head;
    logic   push;
    logic   pop;

    // Classify each byte and queue its results.
    qwt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_line_end  (i_line_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Decouple the two sides so each can stall on its own.
    qwt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (stat)
    );

    // Drain queued commands one result per transfer.
    qwt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_stat     (stat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_char_out (o_char_out)
    );

endmodule

// File: rtl/core/qwt_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts bytes, tracks word and quote state, queues the results per item.
// ----------------------------------------------------------------------------
`include "quoted_word_tokenizer_defines.svh"

module qwt_front
    import qwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  t_qstat     i_stat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        PH_SPACES = 2'd0,
        PH_WORD   = 2'd1,
        PH_QUOTE  = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_qsingle, n_qsingle;
    logic       r_blank, n_blank;
    logic       r_nonempty, n_nonempty;
    logic       r_esc_pending, n_esc_pending;
    logic [7:0] r_esc;

    logic       accept;
    logic       is_ws;
    logic       in_word;
    logic [1:0] n_res;
    t_cmd       cmd;

    assign accept  = i_valid && !i_stat.full;
    assign o_ready = !i_stat.full;
    assign is_ws   = (i_char_in == 8'h20) || (i_char_in >= 8'h09 && i_char_in <= 8'h0D);
    assign in_word = (r_phase == PH_WORD) || (r_phase == PH_QUOTE);

    always_comb begin
        n_phase       = r_phase;
        n_qsingle     = r_qsingle;
        n_blank       = r_blank;
        n_nonempty    = r_nonempty;
        n_esc_pending = r_esc_pending;
        n_res         = 2'd0;
        cmd.two       = 1'b0;
        cmd.r0        = '{kind: KIND_BYTE, ch: i_char_in};
        cmd.r1        = '{kind: KIND_BYTE, ch: i_char_in};

        if (i_line_end) begin
            // close an open word, then mark the end of the line
            if (in_word && (r_blank || r_nonempty)) begin
                n_res  = 2'd2;
                cmd.r0 = '{kind: KIND_EOW, ch: 8'h00};
                cmd.r1 = '{kind: KIND_EOL, ch: 8'h00};
            end else begin
                n_res  = 2'd1;
                cmd.r0 = '{kind: KIND_EOL, ch: 8'h00};
            end
            n_phase       = PH_SPACES;
            n_qsingle     = 1'b0;
            n_blank       = 1'b0;
            n_nonempty    = 1'b0;
            n_esc_pending = 1'b0;
        end else if (r_esc_pending) begin
            // release the held escape byte with its follower
            n_res         = 2'd2;
            cmd.r0        = '{kind: KIND_BYTE, ch: r_esc};
            n_esc_pending = 1'b0;
            n_nonempty    = 1'b1;
        end else if (r_phase == PH_QUOTE) begin
            if (i_char_in == (r_qsingle ? QWT_SQUOTE : QWT_DQUOTE)) begin
                n_phase    = PH_WORD;
                n_nonempty = 1'b1;
                n_res      = 2'd1;
            end else if (i_char_in == r_esc && !r_qsingle) begin
                n_esc_pending = 1'b1;
            end else begin
                n_nonempty = 1'b1;
                n_res      = 2'd1;
            end
        end else if (is_ws) begin
            if (r_phase == PH_WORD && (r_blank || r_nonempty)) begin
                n_res  = 2'd1;
                cmd.r0 = '{kind: KIND_EOW, ch: 8'h00};
            end
            n_phase    = PH_SPACES;
            n_blank    = 1'b0;
            n_nonempty = 1'b0;
        end else if (i_char_in == QWT_SQUOTE || i_char_in == QWT_DQUOTE) begin
            n_qsingle  = (i_char_in == QWT_SQUOTE);
            n_blank    = 1'b1;
            n_phase    = PH_QUOTE;
            n_nonempty = 1'b1;
            n_res      = 2'd1;
        end else if (i_char_in == r_esc) begin
            n_phase       = PH_WORD;
            n_esc_pending = 1'b1;
        end else begin
            n_phase    = PH_WORD;
            n_nonempty = 1'b1;
            n_res      = 2'd1;
        end
        cmd.two = (n_res == 2'd2);
    end

    assign o_push = accept && (n_res != 2'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SPACES;
            r_qsingle     <= 1'b0;
            r_blank       <= 1'b0;
            r_nonempty    <= 1'b0;
            r_esc_pending <= 1'b0;
            r_esc         <= QWT_ESC_RST;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_qsingle     <= n_qsingle;
                r_blank       <= n_blank;
                r_nonempty    <= n_nonempty;
                r_esc_pending <= n_esc_pending;
            end
            if (i_cfg_we) begin
                r_esc <= i_cfg_wdata;
            end
        end
    end

    `QWT_ASSERT_IMPL(a_esc_in_word, i_clk, i_rst_n, r_esc_pending,
        r_phase == PH_WORD || r_phase == PH_QUOTE, "escape held outside a word")
    `QWT_ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, accept && i_line_end,
        !r_esc_pending && r_phase == PH_SPACES, "line state not cleared at end of line")

endmodule

// File: rtl/core/qwt_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer command queue
// Small register FIFO between the front end and the result sequencer.
// ----------------------------------------------------------------------------
`include "quoted_word_tokenizer_defines.svh"

module qwt_queue
    import qwt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_push_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_stat
);

    t_cmd               r_mem [QWT_QDEPTH];
    logic [QWT_QAW-1:0] r_wr_ptr;
    logic [QWT_QAW-1:0] r_rd_ptr;
    logic [QWT_QAW:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QWT_QAW'(0) + (QWT_QAW+1)'(QWT_QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `QWT_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full,
        "push into a full queue")
    `QWT_ASSERT_IMPL(a_ptr_track, i_clk, i_rst_n, r_count == '0 || o_stat.full,
        r_wr_ptr == r_rd_ptr, "queue pointers disagree with fill count")

endmodule

// File: rtl/core/qwt_back.sv
// ----------------------------------------------------------------------------
// Tokenizer result sequencer
// Unpacks queued commands into single results behind an output register.
// ----------------------------------------------------------------------------
`include "quoted_word_tokenizer_defines.svh"

module qwt_back
    import qwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_qstat     i_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_char_out
);

    logic  r_half;
    logic  r_out_valid;
    t_res  r_out;
    logic  load;
    t_res  sel;

    assign load  = (!r_out_valid || i_ready) && !i_stat.empty;
    assign sel   = r_half ? i_head.r1 : i_head.r0;
    assign o_pop = load && (r_half || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_half      <= i_head.two && !r_half;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= sel;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_char_out = r_out.ch;

    `QWT_ASSERT_IMPL(a_half_has_head, i_clk, i_rst_n, r_half, !i_stat.empty,
        "second result pending without a queued command")

endmodule
